@@ src/sal_pkg.sv @@
// ----------------------------------------------------------------------------
// Sequential array list package
// Shared constants, operation and status codes, and the per-cell command
// structure used by the list cells and the top level.
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_FIND   = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
        logic cmp;
        logic scan;
    } t_cell_cmd;

endpackage

@@ src/sal_cell.sv @@
// ----------------------------------------------------------------------------
// Sequential array list cell
// Holds one list entry and one match flag. Shifts data up or down with its
// neighbors and passes its match flag toward cell 0 during a search.
// ----------------------------------------------------------------------------
module sal_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = sal_pkg::DATA_WIDTH_DEF,
    parameter int CMPW       = 6
) (
    input  logic                  i_clk,
    input  sal_pkg::t_cell_cmd    i_cmd,
    input  logic [CMPW-1:0]       i_pos,
    input  logic [CMPW-1:0]       i_count,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_right_match,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_match
);

    localparam logic [CMPW-1:0] MY_POS = CMPW'(IDX + 1);
    localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_match, n_match;

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        if (i_cmd.ins) begin
            if (MY_POS == i_pos) begin
                n_data = i_word;
            end else if (MY_POS > i_pos) begin
                n_data = i_left_data;
            end
        end
        if (i_cmd.del && (MY_POS >= i_pos)) begin
            n_data = i_right_data;
        end
        // Only cells below the fill count take part in a search.
        if (i_cmd.cmp) begin
            n_match = (r_data == i_word) && (MY_IDX < i_count);
        end
        if (i_cmd.scan) begin
            n_match = i_right_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

@@ src/sequential_array_list_unit.sv @@
// ----------------------------------------------------------------------------
// Sequential array list unit
// Ordered list of signed words kept packed from index 0, built as a chain of
// cells, with insert, delete-by-position and find-first-match operations.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high while busy is low, and every
// transaction produces exactly one result, shown for a single cycle with
// o_done high. The receiver cannot stall the block, so the result must be
// captured in that cycle. Insert, delete and the unused operation code never
// leave the idle state: the whole chain of cells shifts in parallel and the
// result strobe follows on the next cycle, while busy stays low throughout.
// Find runs in two phases: when the find is accepted every cell compares its
// entry with the search word, then the match flags march toward cell 0 one
// cell per cycle while an index counter tracks the position. A hit ends the
// search with the first matching index, a miss ends it after the last entry,
// and a find on an empty list misses without searching. The search length
// is set by this flag shift through the chain; busy stays high while it runs.
// ----------------------------------------------------------------------------
module sequential_array_list_unit #(
    parameter int CAPACITY   = sal_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = sal_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sal_pkg::FUNC_W-1:0]    i_func,
    input  logic [sal_pkg::POS_W-1:0]     i_position,
    input  logic signed [sal_pkg::VALUE_W-1:0] i_value,
    output logic                          o_done,
    output logic [sal_pkg::STATUS_W-1:0]  o_status,
    output logic [sal_pkg::IDX_W-1:0]     o_found_index,
    output logic [sal_pkg::COUNT_W-1:0]   o_item_count
);

    // Width of the fill count, of a cell index, and of the position compares.
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = ((CW > sal_pkg::POS_W) ? CW : sal_pkg::POS_W) + 1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [IW-1:0]                 r_idx, n_idx;
    logic                          r_done, n_done;
    sal_pkg::t_status              r_status, n_status;
    logic [IW-1:0]                 r_found, n_found;

    sal_pkg::t_cell_cmd            w_cmd;
    logic [DATA_WIDTH-1:0]         w_word;
    logic [CMPW-1:0]               w_pos;
    logic [CMPW-1:0]               w_cnt;
    logic [DATA_WIDTH-1:0]         w_data  [CAPACITY];
    logic                          w_match [CAPACITY+1];

    // The stored word is the low DATA_WIDTH bits of the input, zero-extended
    // when the list is wider than the port.
    assign w_word = DATA_WIDTH'($unsigned(i_value));
    assign w_pos  = CMPW'(i_position);
    assign w_cnt  = CMPW'(r_count);

    assign w_match[CAPACITY] = 1'b0;

    // Each cell shifts up from its left neighbor on insert and down from its
    // right neighbor on delete; the end cells see harmless stand-in data.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_word;
        end else begin : g_mid_left
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_right
            assign w_right = w_data[g+1];
        end

        sal_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH),
            .CMPW       (CMPW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_pos         (w_pos),
            .i_count       (w_cnt),
            .i_word        (w_word),
            .i_left_data   (w_left),
            .i_right_data  (w_right),
            .i_right_match (w_match[g+1]),
            .o_data        (w_data[g]),
            .o_match       (w_match[g])
        );
    end

    // Operation decode and search sequencing.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_done   = 1'b0;
        n_status = r_status;
        n_found  = r_found;
        w_cmd    = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_found = '0;
                    case (sal_pkg::t_func'(i_func))
                        sal_pkg::FUNC_INSERT: begin
                            n_done = 1'b1;
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = sal_pkg::ST_FULL;
                            end else if ((w_pos == '0) || (w_pos > (w_cnt + CMPW'(1)))) begin
                                n_status = sal_pkg::ST_RANGE;
                            end else begin
                                w_cmd.ins = 1'b1;
                                n_count   = r_count + CW'(1);
                                n_status  = sal_pkg::ST_OK;
                            end
                        end
                        sal_pkg::FUNC_DELETE: begin
                            n_done = 1'b1;
                            if ((w_pos == '0) || (w_pos > w_cnt)) begin
                                n_status = sal_pkg::ST_RANGE;
                            end else begin
                                w_cmd.del = 1'b1;
                                n_count   = r_count - CW'(1);
                                n_status  = sal_pkg::ST_OK;
                            end
                        end
                        sal_pkg::FUNC_FIND: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = sal_pkg::ST_MISS;
                            end else begin
                                w_cmd.cmp = 1'b1;
                                n_idx     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = sal_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Cell 0 holds the flag of the entry at index r_idx.
                if (w_match[0]) begin
                    n_done   = 1'b1;
                    n_status = sal_pkg::ST_OK;
                    n_found  = r_idx;
                    n_state  = S_IDLE;
                end else if ((CW'(r_idx) + CW'(1)) == r_count) begin
                    n_done   = 1'b1;
                    n_status = sal_pkg::ST_MISS;
                    n_found  = '0;
                    n_state  = S_IDLE;
                end else begin
                    w_cmd.scan = 1'b1;
                    n_idx      = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, fill count and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_done   <= 1'b0;
            r_status <= sal_pkg::ST_OK;
            r_found  <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_done   <= n_done;
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_index = sal_pkg::IDX_W'(r_found);
    assign o_item_count  = sal_pkg::COUNT_W'(r_count);

endmodule

@@ sim/sal_list_checker.sv @@
// ----------------------------------------------------------------------------
// Sequential array list checker
// Watches the command and result channels of the list unit, keeps its own
// copy of the list, predicts the answer to every accepted transaction and
// compares each result strobe with the oldest pending answer.
// ----------------------------------------------------------------------------
module sal_list_checker
    import sal_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic [POS_W-1:0]           i_position,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       o_done,
    input  logic [STATUS_W-1:0]        o_status,
    input  logic [IDX_W-1:0]           o_found_index,
    input  logic [COUNT_W-1:0]         o_item_count,
    output int                         o_errors,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   index;
        logic [COUNT_W-1:0] count;
    } t_list_answer;

    // Shadow copy of the list contents and its fill level.
    logic [VALUE_W-1:0] list_words [CAPACITY_DEF];
    int                 list_level;

    t_list_answer expected_answers [$];

    function automatic t_list_answer apply_list_op(t_func op, logic [POS_W-1:0] pos,
                                                   logic [VALUE_W-1:0] word);
        t_list_answer ans;
        int           p;
        p = int'(pos);
        ans.status = ST_OK;
        ans.index  = '0;
        case (op)
            FUNC_INSERT: begin
                if (list_level >= CAPACITY_DEF) begin
                    ans.status = ST_FULL;
                end else if (p < 1 || p > list_level + 1) begin
                    ans.status = ST_RANGE;
                end else begin
                    for (int j = list_level; j >= p; j--)
                        list_words[j] = list_words[j-1];
                    list_words[p-1] = word;
                    list_level++;
                end
            end
            FUNC_DELETE: begin
                if (p < 1 || p > list_level) begin
                    ans.status = ST_RANGE;
                end else begin
                    for (int j = p; j < list_level; j++)
                        list_words[j-1] = list_words[j];
                    list_level--;
                end
            end
            FUNC_FIND: begin
                ans.status = ST_MISS;
                for (int j = 0; j < list_level; j++) begin
                    if (ans.status == ST_MISS && list_words[j] == word) begin
                        ans.status = ST_OK;
                        ans.index  = IDX_W'(j);
                    end
                end
            end
            default: ;
        endcase
        ans.count = COUNT_W'(list_level);
        return ans;
    endfunction

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        list_level = 0;
    end

    always @(posedge i_clk) begin
        t_list_answer want;
        if (!i_rst_n) begin
            expected_answers.delete();
            list_level = 0;
        end else begin
            // A result always belongs to an earlier transaction, so it is
            // checked before this edge's transaction is predicted.
            if (o_done) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result status=%0d index=%0d count=%0d",
                             $time, o_status, o_found_index, o_item_count);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_answers.pop_front();
                    if (o_status !== want.status ||
                        o_found_index !== want.index ||
                        o_item_count !== want.count) begin
                        if (o_status !== want.status)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, want.status, o_status);
                        if (o_found_index !== want.index)
                            $display("%0t: found_index expected %0d actual %0d",
                                     $time, want.index, o_found_index);
                        if (o_item_count !== want.count)
                            $display("%0t: item_count expected %0d actual %0d",
                                     $time, want.count, o_item_count);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (start && !busy)
                expected_answers.push_back(apply_list_op(t_func'(i_func), i_position,
                                                         i_value));
        end
        o_pending <= expected_answers.size();
    end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Sequential array list testbench
// Drives insert, delete, find and unused-code transactions into the list
// unit, first a directed sequence of corner cases and then random phases
// that grow, shrink and churn the list, with random bursts and gaps on the
// command side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sal_pkg::*;

    // Number of random transactions and the stall limit of the watchdog.
    // The slowest transaction is a find that misses on a full list, which
    // scans every entry of the chain before it answers.
    localparam int RANDOM_ITEMS   = 1650;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_CHURN
    } t_fill_mode;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [FUNC_W-1:0]          i_func;
    logic [POS_W-1:0]           i_position;
    logic signed [VALUE_W-1:0]  i_value;
    logic                       o_done;
    logic [STATUS_W-1:0]        o_status;
    logic [IDX_W-1:0]           o_found_index;
    logic [COUNT_W-1:0]         o_item_count;

    int                         error_count;
    int                         pending_count;
    int                         stall_cycles;

    // Last fill level reported by the block. It may lag by a transaction or
    // two, which is fine: it only steers positions toward the valid range.
    int                         seen_level;

    // A few values that recur often so that finds hit and duplicates form.
    logic [VALUE_W-1:0]         hot_values [6];

    sequential_array_list_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_item_count  (o_item_count)
    );

    sal_list_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_item_count  (o_item_count),
        .o_errors      (error_count),
        .o_pending     (pending_count)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n)
            seen_level <= 0;
        else if (o_done)
            seen_level <= int'(o_item_count);
    end

    // The watchdog counts cycles in which neither a transaction nor a result
    // is accepted. A hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("FAIL sequential_array_list_unit");
                $finish;
            end
        end
    end

    // Presents one transaction and holds it until the block takes it. The
    // task is entered just after a falling edge and returns at the first falling
    // edge after the block takes it, with start still high, so back-to-back
    // transactions keep start asserted without a glitch.
    task automatic issue_op(t_func op, int pos, logic [VALUE_W-1:0] word);
        start      <= 1'b1;
        i_func     <= op;
        i_position <= POS_W'(pos);
        i_value    <= word;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Holds the command side quiet until every issued transaction is answered.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 45)
            return hot_values[$urandom_range(0, 5)];
        return VALUE_W'($urandom());
    endfunction

    // Mostly positions inside the valid range for the current fill level,
    // and now and then anything the five-bit field can carry.
    function automatic int pick_position(int upper);
        if (upper >= 1 && $urandom_range(0, 99) < 82)
            return $urandom_range(1, upper);
        return $urandom_range(0, 31);
    endfunction

    task automatic random_op(t_fill_mode mode);
        int    roll;
        t_func op;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:   op = roll < 55 ? FUNC_INSERT : roll < 70 ? FUNC_DELETE :
                              roll < 95 ? FUNC_FIND : FUNC_NOP;
            MODE_SHRINK: op = roll < 15 ? FUNC_INSERT : roll < 65 ? FUNC_DELETE :
                              roll < 95 ? FUNC_FIND : FUNC_NOP;
            default:     op = roll < 35 ? FUNC_INSERT : roll < 65 ? FUNC_DELETE :
                              roll < 95 ? FUNC_FIND : FUNC_NOP;
        endcase
        case (op)
            FUNC_INSERT: issue_op(op, pick_position(seen_level + 1), pick_value());
            FUNC_DELETE: issue_op(op, pick_position(seen_level), pick_value());
            default:     issue_op(op, $urandom_range(0, 31), pick_value());
        endcase
    endtask

    initial begin
        t_fill_mode mode;
        int         phase_left;
        int         burst_left;
        bit         no_gaps;

        hot_values[0] = 32'h8000_0000;
        hot_values[1] = 32'h7FFF_FFFF;
        hot_values[2] = 32'hFFFF_FFFF;
        hot_values[3] = 32'h0000_0000;
        hot_values[4] = 32'h0000_0001;
        hot_values[5] = 32'h5A5A_A5A5;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_func     = FUNC_NOP;
        i_position = '0;
        i_value    = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. An empty list must miss on find and reject deletes.
        issue_op(FUNC_FIND,   0,  32'h0000_0000);
        issue_op(FUNC_DELETE, 1,  32'h0000_0000);
        issue_op(FUNC_DELETE, 0,  32'hFFFF_FFFF);
        // Insert positions outside one to count plus one are refused.
        issue_op(FUNC_INSERT, 0,  32'h1111_1111);
        issue_op(FUNC_INSERT, 2,  32'h2222_2222);
        // Build the list from the extreme words, inserting at the front,
        // the middle and the end.
        issue_op(FUNC_INSERT, 1,  32'h8000_0000);
        issue_op(FUNC_INSERT, 2,  32'h7FFF_FFFF);
        issue_op(FUNC_INSERT, 1,  32'hFFFF_FFFF);
        issue_op(FUNC_INSERT, 4,  32'h0000_0000);
        issue_op(FUNC_INSERT, 2,  32'h7FFF_FFFF);
        // With a duplicate in place, find must report the first match.
        issue_op(FUNC_FIND,   31, 32'h7FFF_FFFF);
        issue_op(FUNC_FIND,   0,  32'h1234_5678);
        issue_op(FUNC_INSERT, 31, 32'h3333_3333);
        issue_op(FUNC_DELETE, 6,  32'h0000_0000);
        issue_op(FUNC_DELETE, 31, 32'h0000_0000);
        // The unused operation code only reports the fill level.
        issue_op(FUNC_NOP,    31, 32'hFFFF_FFFF);
        issue_op(FUNC_DELETE, 5,  32'h0000_0000);
        issue_op(FUNC_DELETE, 1,  32'h0000_0000);
        issue_op(FUNC_FIND,   17, 32'h8000_0000);
        issue_op(FUNC_FIND,   0,  32'h0000_0000);
        wait_for_drain();

        // Random part. Phases push the list toward full or toward empty, or
        // churn it in between, so that inserts into a full list and deletes
        // from an empty one both come up often. The command side runs in
        // bursts separated by gaps, and some phases leave those gaps out.
        phase_left = 0;
        burst_left = 0;
        no_gaps    = 1'b0;
        mode       = MODE_CHURN;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                mode       = t_fill_mode'($urandom_range(0, 2));
                phase_left = $urandom_range(30, 140);
                no_gaps    = ($urandom_range(0, 3) == 0);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (!no_gaps)
                    idle_for($urandom_range(1, 9));
            end
            // Now and then, and once for certain halfway through, the
            // command side waits until the block has answered everything.
            if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0)
                wait_for_drain();
            random_op(mode);
            phase_left--;
            burst_left--;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && pending_count == 0)
            $display("PASS sequential_array_list_unit");
        else
            $display("FAIL sequential_array_list_unit");
        $finish;
    end

endmodule
